/* rtl/let_pkg.sv */
package let_pkg;

  localparam int PIX_W = 8;
  localparam int CFG_DATA_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam int FW_W = 12;
  localparam int FH_W = 13;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

  typedef logic [PIX_W-1:0] pix_t;

endpackage

/* rtl/let_pix_if.sv */
interface let_pix_if;
  import let_pkg::*;

  logic valid;
  logic ready;
  logic cmd;
  pix_t gray_pixel;

  modport source (output valid, output cmd, output gray_pixel, input ready);
  modport sink (input valid, input cmd, input gray_pixel, output ready);
endinterface

/* rtl/let_res_if.sv */
interface let_res_if;
  logic valid;
  logic ready;
  logic edge_res;
  logic frame_last;

  modport source (output valid, output edge_res, output frame_last, input ready);
  modport sink (input valid, input edge_res, input frame_last, output ready);
endinterface

/* rtl/let_line_mem.sv */
module let_line_mem #(
  parameter int DEPTH = 2048,
  parameter int AW = 11
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  let_pkg::pix_t     wr_new,
  input  let_pkg::pix_t     wr_old,
  input  logic [AW-1:0]     rd_addr,
  input  logic [AW-1:0]     rd_right_addr,
  output let_pkg::pix_t     center,
  output let_pkg::pix_t     right,
  output let_pkg::pix_t     up
);
  import let_pkg::*;

  pix_t newer_mem [DEPTH];
  pix_t older_mem [DEPTH];

  pix_t          q_center_r;
  pix_t          q_right_r;
  pix_t          q_up_r;
  logic          wr_v_r;
  logic [AW-1:0] wr_addr_r;
  pix_t          wr_new_r;
  pix_t          wr_old_r;
  logic [AW-1:0] rd_addr_r;
  logic [AW-1:0] rd_right_addr_r;
  logic          hit_center;
  logic          hit_right;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      newer_mem[wr_addr] <= wr_new;
      older_mem[wr_addr] <= wr_old;
    end
    q_center_r      <= newer_mem[rd_addr];
    q_right_r       <= newer_mem[rd_right_addr];
    q_up_r          <= older_mem[rd_addr];
    wr_addr_r       <= wr_addr;
    wr_new_r        <= wr_new;
    wr_old_r        <= wr_old;
    rd_addr_r       <= rd_addr;
    rd_right_addr_r <= rd_right_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_v_r <= 1'b0;
    end else begin
      wr_v_r <= wr_en;
    end
  end

  // A read issued in the same cycle as a write to that entry returns the data being written.
  assign hit_center = wr_v_r && (wr_addr_r == rd_addr_r);
  assign hit_right  = wr_v_r && (wr_addr_r == rd_right_addr_r);

  assign center = hit_center ? wr_new_r : q_center_r;
  assign up     = hit_center ? wr_old_r : q_up_r;
  assign right  = hit_right ? wr_new_r : q_right_r;

endmodule

/* rtl/let_kernel.sv */
module let_kernel (
  input  let_pkg::pix_t center,
  input  let_pkg::pix_t left,
  input  let_pkg::pix_t right,
  input  let_pkg::pix_t up,
  input  let_pkg::pix_t down,
  input  let_pkg::pix_t threshold,
  output logic          edge_res
);
  import let_pkg::*;

  logic [9:0]  pos;
  logic [9:0]  neg;
  logic [10:0] diff;
  pix_t        clamped;

  assign pos  = {center, 2'b00};
  assign neg  = 10'(left) + 10'(right) + 10'(up) + 10'(down);
  assign diff = {1'b0, pos} - {1'b0, neg};

  always_comb begin
    if (diff[10]) begin
      clamped = '0;
    end else if (diff[9:8] != 2'b00) begin
      clamped = '1;
    end else begin
      clamped = diff[7:0];
    end
  end

  assign edge_res = (clamped > threshold);

endmodule

/* rtl/laplacian_edge_threshold.sv */
// A result is registered in the output register at the accepting edge of the item that
// produces it; a pixel's result is produced by the pixel one row below it, or by a drain
// tick after the last row. Throughput: one item per cycle, limited only by the output
// register being held by a stalled sink. Reset is synchronous, clears the counters and
// sets the configuration to its defaults; the line stores are not cleared.
module laplacian_edge_threshold #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk,
  input  logic                                rst_n,
  let_pix_if.sink                             in_ch,
  let_res_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [let_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [let_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import let_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  logic [CW-1:0]   col_r, col_nxt;
  logic [RW-1:0]   row_r, row_nxt;
  pix_t            left_r, left_nxt;
  pix_t            thr_r;
  logic [FW_W-1:0] fw_r;
  logic [FH_W-1:0] fh_r;
  logic            out_valid_r;
  logic            edge_r;
  logic            last_r;

  logic [CW-1:0]   eff_w_m1;
  logic [RW-1:0]   eff_h;
  logic            last_col;
  logic            draining;
  logic            in_fire;
  logic            step_pix;
  logic            step_drain;
  logic            res_valid;
  logic            top_row;
  logic [CW-1:0]   rd_right_addr;
  pix_t            center, right, up;
  pix_t            up_eff, left_eff, right_eff, down_eff;
  logic            edge_res;

  always_comb begin
    if (fw_r == '0) begin
      eff_w_m1 = '0;
    end else if (32'(fw_r) > MAX_WIDTH) begin
      eff_w_m1 = CW'(MAX_WIDTH - 1);
    end else begin
      eff_w_m1 = CW'(fw_r - 1'b1);
    end
    if (fh_r == '0) begin
      eff_h = RW'(1);
    end else if (32'(fh_r) > MAX_HEIGHT) begin
      eff_h = RW'(MAX_HEIGHT);
    end else begin
      eff_h = RW'(fh_r);
    end
  end

  assign last_col   = (col_r == eff_w_m1);
  assign draining   = (row_r >= eff_h);
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign step_pix   = in_fire && (in_ch.cmd == CMD_PIXEL) && !draining;
  assign step_drain = in_fire && (in_ch.cmd == CMD_DRAIN) && draining;
  assign res_valid  = (step_pix && (row_r != '0)) || step_drain;
  assign top_row    = (in_ch.cmd == CMD_PIXEL) ? (row_r == RW'(1)) : (eff_h == RW'(1));

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    left_nxt = left_r;
    if (step_pix || step_drain) begin
      left_nxt = center;
      if (last_col) begin
        col_nxt = '0;
        row_nxt = step_pix ? (row_r + 1'b1) : '0;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    if (cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT)) begin
      col_nxt = '0;
      row_nxt = '0;
    end
  end

  assign rd_right_addr = (col_nxt == CW'(MAX_WIDTH - 1)) ? '0 : (col_nxt + 1'b1);

  let_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_mem (
    .clk           (clk),
    .rst_n         (rst_n),
    .wr_en         (step_pix),
    .wr_addr       (col_r),
    .wr_new        (in_ch.gray_pixel),
    .wr_old        (center),
    .rd_addr       (col_nxt),
    .rd_right_addr (rd_right_addr),
    .center        (center),
    .right         (right),
    .up            (up)
  );

  assign up_eff    = top_row ? center : up;
  assign left_eff  = (col_r == '0) ? center : left_r;
  assign right_eff = last_col ? center : right;
  assign down_eff  = step_drain ? center : in_ch.gray_pixel;

  let_kernel u_kernel (
    .center    (center),
    .left      (left_eff),
    .right     (right_eff),
    .up        (up_eff),
    .down      (down_eff),
    .threshold (thr_r),
    .edge_res  (edge_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      left_r      <= '0;
      thr_r       <= '0;
      fw_r        <= FW_W'(1);
      fh_r        <= FH_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      left_r <= left_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_THRESHOLD: thr_r <= cfg_data[PIX_W-1:0];
          CFG_WIDTH:     fw_r  <= cfg_data[FW_W-1:0];
          CFG_HEIGHT:    fh_r  <= cfg_data[FH_W-1:0];
          default: ;
        endcase
      end
      if (res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      edge_r <= edge_res;
      last_r <= step_drain && last_col;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.edge_res   = edge_r;
  assign out_ch.frame_last = last_r;

endmodule
